### design/burh_pkg.sv
`timescale 1ns / 1ps

package burh_pkg;

  // Ring depth must stay a power of two: ring offsets wrap by truncation.
  localparam int RING_DEPTH = 64;
  localparam int IW         = $clog2(RING_DEPTH);
  localparam int DW         = IW + 1;
  localparam int LIM_MAX    = RING_DEPTH - 1;

  localparam int OPW  = 3;
  localparam int ESW  = 24;
  localparam int SUMW = 32;
  localparam int CLW  = 6;
  localparam int BLW  = 32;
  localparam int OUTW = 6;

  typedef enum logic [OPW-1:0] {
    OP_EXECUTE      = 3'd0,
    OP_UNDO         = 3'd1,
    OP_REDO         = 3'd2,
    OP_MARK_CLEAN   = 3'd3,
    OP_APPLY_LIMITS = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_MAX_ENTRIES = 2'd0,
    REG_BYTE_LIMIT  = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic            we;
    logic [IW-1:0]   waddr;
    logic [ESW-1:0]  wdata;
    logic [IW-1:0]   raddr;
  } ring_req_t;

  typedef struct packed {
    logic [OUTW-1:0] undo_entries;
    logic [OUTW-1:0] redo_entries;
    logic [SUMW-1:0] undo_bytes;
    logic [SUMW-1:0] redo_bytes;
    logic            potential_clean;
    logic            marker_valid;
  } result_t;

endpackage

### design/burh_ring.sv
`timescale 1ns / 1ps

module burh_ring
  import burh_pkg::*;
(
  input  logic            clk,
  input  ring_req_t       req,
  output logic [ESW-1:0]  rdata
);

  logic [ESW-1:0] mem [RING_DEPTH];
  logic [ESW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/burh_ctrl.sv
`timescale 1ns / 1ps

module burh_ctrl
  import burh_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  op_t             in_op,
  input  logic [ESW-1:0]  in_size,
  input  logic            in_ok,
  input  logic [CLW-1:0]  max_entries,
  input  logic [BLW-1:0]  byte_limit,
  output ring_req_t       ring_req,
  input  logic [ESW-1:0]  ring_rdata,
  input  logic            res_free,
  output logic            res_load,
  output result_t         res
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_PREP  = 6'b001000,
    S_EVICT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  op_t             op_r, op_nxt;
  logic [ESW-1:0]  size_r, size_nxt;
  logic            ok_r, ok_nxt;
  logic [IW-1:0]   oldest_r, oldest_nxt;
  logic [DW-1:0]   undo_r, undo_nxt;
  logic [DW-1:0]   redo_r, redo_nxt;
  logic [SUMW-1:0] usum_r, usum_nxt;
  logic [SUMW-1:0] rsum_r, rsum_nxt;
  logic [DW-1:0]   mark_r, mark_nxt;
  logic            held_r, held_nxt;
  logic            pot_r, pot_nxt;
  logic [DW-1:0]   before_r, before_nxt;
  logic [DW-1:0]   cnt_room_r, cnt_room_nxt;
  logic [SUMW-1:0] room_r, room_nxt;

  logic [DW-1:0]   lim;
  logic            cnt_ex, byte_ex, drop;
  logic [DW-1:0]   delta;
  logic [DW-1:0]   undo_dec, undo_inc;
  logic [SUMW-1:0] q_ext;

  assign lim = (DW'(max_entries) > DW'(LIM_MAX)) ? DW'(LIM_MAX) : DW'(max_entries);
  assign q_ext    = SUMW'(ring_rdata);
  assign undo_dec = undo_r - DW'(1);
  assign undo_inc = undo_r + DW'(1);

  // one eviction per cycle: ring data is the size at oldest_r
  assign cnt_ex  = undo_r > cnt_room_r;
  assign byte_ex = (usum_r > room_r) && (undo_r != '0);
  assign drop    = cnt_ex || byte_ex;
  assign delta   = before_r - undo_r;

  assign in_ready = (state_r == S_IDLE);
  assign res_load = (state_r == S_DONE) && res_free;

  assign res.undo_entries    = undo_r[OUTW-1:0];
  assign res.redo_entries    = redo_r[OUTW-1:0];
  assign res.undo_bytes      = usum_r;
  assign res.redo_bytes      = rsum_r;
  assign res.potential_clean = pot_r;
  assign res.marker_valid    = held_r;

  always_comb begin
    ring_req.we    = 1'b0;
    ring_req.waddr = oldest_r + undo_r[IW-1:0];
    ring_req.wdata = size_r;
    ring_req.raddr = oldest_r;
    case (state_r)
      S_READ: begin
        if (op_r == OP_UNDO) begin
          ring_req.raddr = oldest_r + undo_dec[IW-1:0];
        end else begin
          ring_req.raddr = oldest_r + undo_r[IW-1:0];
        end
      end
      S_EXEC: begin
        ring_req.we = (op_r == OP_EXECUTE) && ok_r;
      end
      S_EVICT: begin
        if (drop) begin
          ring_req.raddr = oldest_r + IW'(1);
        end
      end
      default: begin
        ring_req.raddr = oldest_r;
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    size_nxt     = size_r;
    ok_nxt       = ok_r;
    oldest_nxt   = oldest_r;
    undo_nxt     = undo_r;
    redo_nxt     = redo_r;
    usum_nxt     = usum_r;
    rsum_nxt     = rsum_r;
    mark_nxt     = mark_r;
    held_nxt     = held_r;
    pot_nxt      = pot_r;
    before_nxt   = before_r;
    cnt_room_nxt = cnt_room_r;
    room_nxt     = room_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          size_nxt  = in_size;
          ok_nxt    = in_ok;
          pot_nxt   = 1'b0;
          state_nxt = S_READ;
        end
      end

      S_READ: begin
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        state_nxt = S_PREP;
        case (op_r)
          OP_EXECUTE: begin
            redo_nxt = '0;
            rsum_nxt = '0;
            if (ok_r) begin
              if (held_r && (mark_r > undo_r)) begin
                held_nxt = 1'b0;
              end
              undo_nxt = undo_inc;
              usum_nxt = usum_r + SUMW'(size_r);
            end else begin
              oldest_nxt = oldest_r + undo_r[IW-1:0];
              undo_nxt   = '0;
              usum_nxt   = '0;
              if (held_r && (mark_r != '0)) begin
                held_nxt = 1'b0;
              end
            end
          end
          OP_UNDO: begin
            if (undo_r != '0) begin
              if (ok_r) begin
                undo_nxt = undo_dec;
                usum_nxt = usum_r - q_ext;
                redo_nxt = redo_r + DW'(1);
                rsum_nxt = rsum_r + q_ext;
                pot_nxt  = held_r && ((undo_dec == mark_r) || (undo_r == mark_r));
              end else begin
                // top entry and the rest of undo go; redo stays
                if (held_r) begin
                  if (mark_r <= undo_dec) begin
                    held_nxt = 1'b0;
                  end else begin
                    mark_nxt = mark_r - undo_r;
                  end
                end
                oldest_nxt = oldest_r + undo_r[IW-1:0];
                undo_nxt   = '0;
                usum_nxt   = '0;
              end
            end
          end
          OP_REDO: begin
            if (redo_r != '0) begin
              if (ok_r) begin
                redo_nxt = redo_r - DW'(1);
                rsum_nxt = rsum_r - q_ext;
                undo_nxt = undo_inc;
                usum_nxt = usum_r + q_ext;
                pot_nxt  = held_r && ((undo_inc == mark_r) ||
                                      (undo_inc == mark_r + DW'(1)));
              end else begin
                if (held_r && (mark_r > undo_r)) begin
                  held_nxt = 1'b0;
                end
                redo_nxt = '0;
                rsum_nxt = '0;
              end
            end
          end
          OP_MARK_CLEAN: begin
            mark_nxt = undo_r;
            held_nxt = 1'b1;
          end
          default: begin
            state_nxt = S_PREP;
          end
        endcase
      end

      S_PREP: begin
        before_nxt   = undo_r;
        cnt_room_nxt = lim - redo_r;
        room_nxt     = byte_limit - rsum_r;
        if ((redo_r >= lim) || (rsum_r >= byte_limit)) begin
          oldest_nxt = oldest_r + undo_r[IW-1:0];
          undo_nxt   = '0;
          usum_nxt   = '0;
        end
        state_nxt = S_EVICT;
      end

      S_EVICT: begin
        if (drop) begin
          usum_nxt   = usum_r - q_ext;
          oldest_nxt = oldest_r + IW'(1);
          undo_nxt   = undo_dec;
        end else begin
          if (held_r) begin
            if (mark_r >= delta) begin
              mark_nxt = mark_r - delta;
            end else begin
              held_nxt = 1'b0;
            end
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (res_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      oldest_r <= '0;
      undo_r   <= '0;
      redo_r   <= '0;
      usum_r   <= '0;
      rsum_r   <= '0;
      mark_r   <= '0;
      held_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      undo_r   <= undo_nxt;
      redo_r   <= redo_nxt;
      usum_r   <= usum_nxt;
      rsum_r   <= rsum_nxt;
      mark_r   <= mark_nxt;
      held_r   <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    size_r     <= size_nxt;
    ok_r       <= ok_nxt;
    pot_r      <= pot_nxt;
    before_r   <= before_nxt;
    cnt_room_r <= cnt_room_nxt;
    room_r     <= room_nxt;
  end

`ifndef NO_ASSERTIONS
  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((DW+1)'(undo_r) + (DW+1)'(redo_r) <= (DW+1)'(LIM_MAX)))
    else $error("undo plus redo entries exceed ring bound");

  a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EVICT) && drop) |-> (undo_r != '0))
    else $error("eviction from empty undo stack");

  a_undo_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) && (undo_r == '0)) |-> (usum_r == '0))
    else $error("undo bytes nonzero with empty undo stack");

  a_redo_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) && (redo_r == '0)) |-> (rsum_r == '0))
    else $error("redo bytes nonzero with empty redo stack");

  a_load_returns: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after result load");
`endif

endmodule

### design/bounded_undo_redo_history_core.sv
`timescale 1ns / 1ps

// Bounded undo/redo history: entry sizes live in a 64-word ring (one write, one
// registered read port) holding the undo stack with the redo stack above it, plus
// running byte totals; the entry-count and byte limits are written over the APB port;
// the user must write them only while the block is idle; it is not enforced.
// An accepted input transaction passes the read, execute and prepare states, then the
// eviction state, which evicts oldest undo entries over the limits, then the done state
// until its result is loaded, then idle. The eviction walk reads one ring word per
// cycle through a single subtract unit. The block takes no new input transaction until
// the result is loaded into the output register, which waits while a previous result
// is still unaccepted. No clearing pass follows reset.
module bounded_undo_redo_history_core
  import burh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // operation[2:0], entry_size[26:3], zero pad
  input  logic [0:0]  in_tuser,   // action_ok[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // undo_entries[5:0], redo_entries[11:6], undo_bytes[43:12], redo_bytes[75:44], pad
  output logic [79:0] out_tdata,
  output logic [1:0]  out_tuser,  // potential_clean[0], marker_valid[1]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [CLW-1:0]  max_entries_r;
  logic [BLW-1:0]  byte_limit_r;
  logic            cfg_wr;
  reg_idx_t        cfg_idx;

  ring_req_t       ring_req;
  logic [ESW-1:0]  ring_rdata;

  logic            res_free, res_load;
  result_t         res;
  result_t         out_r;
  logic            out_valid_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[2] ? REG_BYTE_LIMIT : REG_MAX_ENTRIES;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= CLW'(LIM_MAX);
      byte_limit_r  <= '1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MAX_ENTRIES: max_entries_r <= cfg_pwdata[CLW-1:0];
        REG_BYTE_LIMIT:  byte_limit_r  <= cfg_pwdata[BLW-1:0];
        default: begin
          max_entries_r <= max_entries_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MAX_ENTRIES: cfg_prdata = 32'(max_entries_r);
      REG_BYTE_LIMIT:  cfg_prdata = byte_limit_r;
      default:         cfg_prdata = '0;
    endcase
  end

  burh_ring u_ring (
    .clk   (clk),
    .req   (ring_req),
    .rdata (ring_rdata)
  );

  burh_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (op_t'(in_tdata[OPW-1:0])),
    .in_size     (in_tdata[OPW+ESW-1:OPW]),
    .in_ok       (in_tuser[0]),
    .max_entries (max_entries_r),
    .byte_limit  (byte_limit_r),
    .ring_req    (ring_req),
    .ring_rdata  (ring_rdata),
    .res_free    (res_free),
    .res_load    (res_load),
    .res         (res)
  );

  assign res_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_r.redo_bytes, out_r.undo_bytes,
                       out_r.redo_entries, out_r.undo_entries};
  assign out_tuser  = {out_r.marker_valid, out_r.potential_clean};

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench
  import burh_pkg::*;
();

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DIR_N        = 25;

  // operation codes with no function of their own; the block treats them as apply limits
  localparam logic [OPW-1:0] OP_SPARE5 = 3'd5;
  localparam logic [OPW-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OPW-1:0] OP_SPARE7 = 3'd7;

  localparam int SZ_SMALL = 0;
  localparam int SZ_FULL  = 1;
  localparam int SZ_MIXED = 2;

  typedef struct packed {
    logic [OPW-1:0] op;
    logic [ESW-1:0] size;
    logic           ok;
    logic           typed;
    result_t        want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bounded_undo_redo_history_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // history mirror
  logic [ESW-1:0]  size_mem [RING_DEPTH];
  logic [IW-1:0]   base_idx;
  int unsigned     undo_n;
  int unsigned     redo_n;
  logic [63:0]     undo_total;
  logic [63:0]     redo_total;
  int unsigned     mark_pos;
  bit              mark_on;
  logic [CLW-1:0]  lim_count;
  logic [BLW-1:0]  lim_bytes;

  result_t         expected_q [$];
  int              err_cnt;
  int              cycle_cnt;
  int              tx_burst;
  bit              hold_req;
  int              rx_left;
  int              rx_mode;

  dir_row_t dir_tab [DIR_N] = '{
    {OP_APPLY_LIMITS, 24'd0,       1'b1, 1'b1, 6'd0, 6'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    {OP_UNDO,         24'd0,       1'b1, 1'b1, 6'd0, 6'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    {OP_REDO,         24'd0,       1'b1, 1'b1, 6'd0, 6'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    {OP_MARK_CLEAN,   24'd0,       1'b1, 1'b1, 6'd0, 6'd0, 32'd0, 32'd0, 1'b0, 1'b1},
    {OP_EXECUTE,      24'hFFFFFF,  1'b1, 1'b1, 6'd1, 6'd0, 32'hFFFFFF, 32'd0, 1'b0, 1'b1},
    {OP_EXECUTE,      24'h000000,  1'b1, 1'b0, 78'd0},
    {OP_MARK_CLEAN,   24'h123456,  1'b0, 1'b0, 78'd0},
    {OP_EXECUTE,      24'h000ABC,  1'b1, 1'b0, 78'd0},
    {OP_UNDO,         24'h000000,  1'b1, 1'b0, 78'd0},
    {OP_UNDO,         24'hFFFFFF,  1'b1, 1'b0, 78'd0},
    {OP_UNDO,         24'h000000,  1'b1, 1'b0, 78'd0},
    {OP_REDO,         24'h000000,  1'b1, 1'b0, 78'd0},
    {OP_REDO,         24'h000000,  1'b1, 1'b0, 78'd0},
    {OP_EXECUTE,      24'h800000,  1'b1, 1'b0, 78'd0},
    {OP_UNDO,         24'h000000,  1'b0, 1'b0, 78'd0},
    {OP_REDO,         24'h000000,  1'b1, 1'b0, 78'd0},
    {OP_REDO,         24'h000000,  1'b0, 1'b0, 78'd0},
    {OP_EXECUTE,      24'h000001,  1'b1, 1'b0, 78'd0},
    {OP_EXECUTE,      24'h7FFFFF,  1'b0, 1'b0, 78'd0},
    {OP_SPARE5,       24'hFFFFFF,  1'b1, 1'b0, 78'd0},
    {OP_SPARE6,       24'h000000,  1'b0, 1'b0, 78'd0},
    {OP_SPARE7,       24'hA5A5A5,  1'b1, 1'b0, 78'd0},
    {OP_EXECUTE,      24'h555555,  1'b1, 1'b0, 78'd0},
    {OP_EXECUTE,      24'hAAAAAA,  1'b1, 1'b0, 78'd0},
    {OP_UNDO,         24'h000000,  1'b0, 1'b0, 78'd0}
  };

  function automatic logic [IW-1:0] slot(int unsigned off);
    return IW'(base_idx + off);
  endfunction

  function automatic void evict_oldest();
    undo_total -= size_mem[base_idx];
    base_idx = slot(1);
    undo_n--;
  endfunction

  function automatic void drop_all_undo();
    base_idx = slot(undo_n);
    undo_n = 0;
    undo_total = 0;
  endfunction

  function automatic logic [31:0] sat32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // applies one operation to the mirror and returns the counts it leaves behind
  function automatic result_t history_step(logic [OPW-1:0] op, logic [ESW-1:0] sz_in, bit ok);
    logic [ESW-1:0] sz;
    int unsigned    before_n;
    int unsigned    lim;
    int unsigned    delta;
    logic [63:0]    room;
    bit             pot;
    result_t        r;
    pot = 1'b0;
    case (op)
      OP_EXECUTE: begin
        if (ok) begin
          if (mark_on && mark_pos > undo_n) mark_on = 1'b0;
          size_mem[slot(undo_n)] = sz_in;
          undo_n++;
          undo_total += sz_in;
          redo_n = 0;
          redo_total = 0;
        end else begin
          drop_all_undo();
          redo_n = 0;
          redo_total = 0;
          if (mark_on && mark_pos > 0) mark_on = 1'b0;
        end
      end
      OP_UNDO: begin
        if (undo_n > 0) begin
          sz = size_mem[slot(undo_n - 1)];
          undo_n--;
          undo_total -= sz;
          if (ok) begin
            redo_n++;
            redo_total += sz;
            if (mark_on && (undo_n == mark_pos || undo_n + 1 == mark_pos)) pot = 1'b1;
          end else begin
            if (mark_on) begin
              if (mark_pos <= undo_n) mark_on = 1'b0;
              else mark_pos -= undo_n + 1;
            end
            drop_all_undo();
            // skip the failed entry too
            base_idx = slot(1);
          end
        end
      end
      OP_REDO: begin
        if (redo_n > 0) begin
          sz = size_mem[slot(undo_n)];
          redo_n--;
          redo_total -= sz;
          if (ok) begin
            undo_n++;
            undo_total += sz;
            if (mark_on && (undo_n == mark_pos || undo_n == mark_pos + 1)) pot = 1'b1;
          end else begin
            if (mark_on && mark_pos > undo_n) mark_on = 1'b0;
            redo_n = 0;
            redo_total = 0;
          end
        end
      end
      OP_MARK_CLEAN: begin
        mark_pos = undo_n;
        mark_on = 1'b1;
      end
      default: ;
    endcase

    before_n = undo_n;
    lim = (lim_count > LIM_MAX) ? LIM_MAX : lim_count;
    if (redo_n >= lim) drop_all_undo();
    else while (undo_n > lim - redo_n) evict_oldest();
    if (redo_total >= {32'd0, lim_bytes}) begin
      drop_all_undo();
    end else begin
      room = {32'd0, lim_bytes} - redo_total;
      while (undo_total > room && undo_n > 0) evict_oldest();
    end
    delta = before_n - undo_n;
    if (mark_on) begin
      if (mark_pos >= delta) mark_pos -= delta;
      else mark_on = 1'b0;
    end

    r.undo_entries    = undo_n[OUTW-1:0];
    r.redo_entries    = redo_n[OUTW-1:0];
    r.undo_bytes      = sat32(undo_total);
    r.redo_bytes      = sat32(redo_total);
    r.potential_clean = pot;
    r.marker_valid    = mark_on;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (err_cnt < 100)
      $display("mismatch %s: got %0h, want %0h at cycle %0d", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  task automatic check_result(result_t got, result_t want);
    if (got.undo_entries !== want.undo_entries)
      report_mismatch("undo_entries", 64'(got.undo_entries), 64'(want.undo_entries));
    if (got.redo_entries !== want.redo_entries)
      report_mismatch("redo_entries", 64'(got.redo_entries), 64'(want.redo_entries));
    if (got.undo_bytes !== want.undo_bytes)
      report_mismatch("undo_bytes", 64'(got.undo_bytes), 64'(want.undo_bytes));
    if (got.redo_bytes !== want.redo_bytes)
      report_mismatch("redo_bytes", 64'(got.redo_bytes), 64'(want.redo_bytes));
    if (got.potential_clean !== want.potential_clean)
      report_mismatch("potential_clean", 64'(got.potential_clean),
                      64'(want.potential_clean));
    if (got.marker_valid !== want.marker_valid)
      report_mismatch("marker_valid", 64'(got.marker_valid), 64'(want.marker_valid));
  endtask

  task automatic apb_write(reg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = 3'(idx * 4);
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_MAX_ENTRIES: lim_count = data[CLW-1:0];
      REG_BYTE_LIMIT:  lim_bytes = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // one input transaction; valid stays high across a burst
  task automatic send_item(logic [OPW-1:0] op, logic [ESW-1:0] size, bit ok, bit typed,
                           result_t want);
    result_t pred;
    @(negedge clk);
    if (tx_burst == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      tx_burst = $urandom_range(1, 16);
    end
    in_tdata  = {5'd0, size, op};
    in_tuser  = ok;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    tx_burst--;
    pred = history_step(op, size, ok);
    expected_q.insert(expected_q.size(), typed ? want : pred);
  endtask

  task automatic settle_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [ESW-1:0] pick_size(int mode);
    logic [ESW-1:0] s;
    s = ESW'($urandom);
    case (mode)
      SZ_SMALL: s = ESW'($urandom_range(0, 255));
      SZ_MIXED: begin
        case ($urandom_range(0, 3))
          0: s = '0;
          1: s = '1;
          2: s = ESW'($urandom_range(0, 4095));
          default: ;
        endcase
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic run_phase(int n, int size_mode, int exec_w);
    logic [OPW-1:0] op;
    logic [ESW-1:0] size;
    bit             ok;
    int             roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      ok   = ($urandom_range(0, 19) != 0);
      size = ESW'($urandom);
      if (roll < exec_w) begin
        op   = OP_EXECUTE;
        size = pick_size(size_mode);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 40)      op = OP_UNDO;
        else if (roll < 80) op = OP_REDO;
        else if (roll < 90) op = OP_MARK_CLEAN;
        else if (roll < 95) op = OP_APPLY_LIMITS;
        else begin
          case ($urandom_range(0, 2))
            0:       op = OP_SPARE5;
            1:       op = OP_SPARE6;
            default: op = OP_SPARE7;
          endcase
          ok = ($urandom_range(0, 1) != 0);
        end
      end
      send_item(op, size, ok, 1'b0, '0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL bounded_undo_redo_history_core");
    $finish;
  end

  // receiver: changes its stall pattern now and then; a hold request forces a long stall
  initial begin
    out_tready = 1'b0;
    rx_left    = 0;
    rx_mode    = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_left = $urandom_range(20, 80);
        end
        rx_left--;
        case (rx_mode)
          0:       out_tready = 1'b1;
          1:       out_tready = ($urandom_range(0, 1) != 0);
          default: out_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.undo_entries    = out_tdata[5:0];
      got.redo_entries    = out_tdata[11:6];
      got.undo_bytes      = out_tdata[43:12];
      got.redo_bytes      = out_tdata[75:44];
      got.potential_clean = out_tuser[0];
      got.marker_valid    = out_tuser[1];
      if (expected_q.size() == 0) report_mismatch("unexpected result", out_tdata[63:0], 64'd0);
      else check_result(got, expected_q.pop_front());
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    hold_req    = 1'b0;
    err_cnt     = 0;
    tx_burst    = 0;
    for (int i = 0; i < RING_DEPTH; i++) size_mem[i] = '0;
    base_idx   = '0;
    undo_n     = 0;
    redo_n     = 0;
    undo_total = 0;
    redo_total = 0;
    mark_pos   = 0;
    mark_on    = 1'b0;
    lim_count  = 6'd63;
    lim_bytes  = 32'hFFFF_FFFF;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed pass with the reset limits
    foreach (dir_tab[i])
      send_item(dir_tab[i].op, dir_tab[i].size, dir_tab[i].ok, dir_tab[i].typed,
                dir_tab[i].want);
    settle_idle();

    // fill to the count limit while the receiver holds off
    apb_write(REG_MAX_ENTRIES, 32'd63);
    apb_write(REG_BYTE_LIMIT, 32'hFFFF_FFFF);
    hold_req = 1'b1;
    run_phase(80, SZ_FULL, 80);
    settle_idle();

    // zero count limit empties undo every time
    apb_write(REG_MAX_ENTRIES, 32'd0);
    run_phase(25, SZ_MIXED, 50);
    settle_idle();

    apb_write(REG_MAX_ENTRIES, 32'd1);
    run_phase(30, SZ_MIXED, 50);
    settle_idle();

    // byte eviction with large entries
    apb_write(REG_MAX_ENTRIES, 32'd7);
    apb_write(REG_BYTE_LIMIT, 32'h0300_0000);
    run_phase(60, SZ_FULL, 55);
    settle_idle();

    apb_write(REG_MAX_ENTRIES, 32'd63);
    apb_write(REG_BYTE_LIMIT, 32'd0);
    run_phase(25, SZ_MIXED, 50);
    settle_idle();

    apb_write(REG_MAX_ENTRIES, 32'd12);
    apb_write(REG_BYTE_LIMIT, 32'd1000);
    run_phase(50, SZ_SMALL, 55);
    settle_idle();

    apb_write(REG_MAX_ENTRIES, 32'd40);
    apb_write(REG_BYTE_LIMIT, $urandom);
    run_phase(60, SZ_MIXED, 60);
    settle_idle();

    apb_write(REG_MAX_ENTRIES, 32'd63);
    apb_write(REG_BYTE_LIMIT, 32'hFFFF_FFFF);
    run_phase(60, SZ_MIXED, 45);
    settle_idle();

    apb_write(REG_MAX_ENTRIES, 32'd2);
    apb_write(REG_BYTE_LIMIT, 32'h00FF_FFFF);
    run_phase(40, SZ_FULL, 50);
    settle_idle();

    repeat (100) @(posedge clk);
    if (err_cnt == 0)
      $display("PASS bounded_undo_redo_history_core");
    else
      $display("FAIL bounded_undo_redo_history_core");
    $finish;
  end

endmodule
